### rtl/basic_program_token_parser_macros.svh
// Assertion macros shared by the token parser RTL.
`ifndef BASIC_PROGRAM_TOKEN_PARSER_MACROS_SVH
`define BASIC_PROGRAM_TOKEN_PARSER_MACROS_SVH

// Same-cycle implication, checked on the parser clock outside reset.
`define TKP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the parser clock outside reset.
`define TKP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tkp_pkg.sv
// Types, codes and constants of the tokenized BASIC program parser.
package tkp_pkg;

    localparam int unsigned C_PREFIX_BYTES = 16;
    localparam int unsigned C_PREFIX_W     = 8;
    localparam int unsigned C_VALUE_W      = 56;
    localparam int unsigned C_LANES        = C_VALUE_W / 8;

    typedef enum logic [2:0] {
        PH_START,
        PH_LINK_LO,
        PH_LINK_HI,
        PH_NUM_LO,
        PH_NUM_HI,
        PH_BODY,
        PH_OPERAND,
        PH_HALT
    } t_phase;

    // Token kinds on the result channel.
    localparam logic [4:0] K_LINE_START   = 5'd0;
    localparam logic [4:0] K_END_LINE     = 5'd1;
    localparam logic [4:0] K_OCTAL        = 5'd2;
    localparam logic [4:0] K_HEX          = 5'd3;
    localparam logic [4:0] K_LINE_REF     = 5'd4;
    localparam logic [4:0] K_SMALL_CONST  = 5'd5;
    localparam logic [4:0] K_SIGNED_INT   = 5'd6;
    localparam logic [4:0] K_FLOAT4       = 5'd7;
    localparam logic [4:0] K_FLOAT8       = 5'd8;
    localparam logic [4:0] K_KEYWORD      = 5'd9;
    localparam logic [4:0] K_FUNCTION     = 5'd10;
    localparam logic [4:0] K_IEEE         = 5'd11;
    localparam logic [4:0] K_CHAR         = 5'd12;
    localparam logic [4:0] K_STMT_BREAK   = 5'd13;
    localparam logic [4:0] K_UNKNOWN      = 5'd14;
    localparam logic [4:0] K_ABS_ADDR     = 5'd15;
    localparam logic [4:0] K_END_PROGRAM  = 5'd16;
    localparam logic [4:0] K_ERROR        = 5'd17;

    // Byte codes of the program image.
    localparam logic [7:0] B_LINE_END     = 8'h00;
    localparam logic [7:0] B_OCTAL        = 8'h0B;
    localparam logic [7:0] B_HEX          = 8'h0C;
    localparam logic [7:0] B_ABS_ADDR     = 8'h0D;
    localparam logic [7:0] B_LINE_REF     = 8'h0E;
    localparam logic [7:0] B_BYTE_CONST   = 8'h0F;
    localparam logic [7:0] B_SMALL_LO     = 8'h11;
    localparam logic [7:0] B_SMALL_HI     = 8'h1A;
    localparam logic [7:0] B_SIGNED_INT   = 8'h1C;
    localparam logic [7:0] B_FLOAT4       = 8'h1D;
    localparam logic [7:0] B_FLOAT8       = 8'h1F;
    localparam logic [7:0] B_PRINT_LO     = 8'h20;
    localparam logic [7:0] B_QUOTE        = 8'h22;
    localparam logic [7:0] B_COLON        = 8'h3A;
    localparam logic [7:0] B_PRINT_HI     = 8'h7E;
    localparam logic [7:0] B_KW_LO        = 8'h81;
    localparam logic [7:0] B_DATA         = 8'h84;
    localparam logic [7:0] B_REM          = 8'h8F;
    localparam logic [7:0] B_FUNC_HI      = 8'hAD;
    localparam logic [7:0] B_KANA_LO      = 8'hA1;
    localparam logic [7:0] B_KANA_HI      = 8'hDF;
    localparam logic [7:0] B_IEEE         = 8'hEC;
    localparam logic [7:0] B_KW_HI        = 8'hFE;
    localparam logic [7:0] B_FUNC_PREFIX  = 8'hFF;

    // Configuration register indexes.
    localparam logic CFG_PRETTY_LAYOUT    = 1'b0;
    localparam logic CFG_SKIP_TAPE_PREFIX = 1'b1;

    typedef struct packed {
        t_phase                  phase;
        logic [C_PREFIX_W-1:0]   prefix_count;
        logic [3:0]              op_kind;
        logic [3:0]              bytes_left;
        logic [2:0]              op_shift;
        logic [C_VALUE_W-1:0]    assembly;
        logic                    link_lo_zero;
        logic                    quote;
        logic                    rem_data;
    } t_parse_state;

    typedef struct packed {
        logic [4:0]              kind;
        logic [C_VALUE_W-1:0]    value;
        logic [7:0]              expo;
    } t_token;

    localparam t_parse_state C_STATE_RESET = '{
        PH_START, {C_PREFIX_W{1'b0}}, 4'd0, 4'd0, 3'd0, {C_VALUE_W{1'b0}}, 1'b0, 1'b0, 1'b0
    };

endpackage

### rtl/tkp_decode.sv
// Single-byte parse step: next parse state and the token that the byte completes.
module tkp_decode #(
    parameter int unsigned PREFIX_BYTES = tkp_pkg::C_PREFIX_BYTES
) (
    input  tkp_pkg::t_parse_state i_state,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_end_of_input,
    input  logic                  i_pretty_layout,
    input  logic                  i_skip_prefix,
    output tkp_pkg::t_parse_state o_state,
    output logic                  o_token_valid,
    output tkp_pkg::t_token       o_token
);
    import tkp_pkg::*;

    localparam logic [C_PREFIX_W-1:0] LP_PREFIX = C_PREFIX_W'(PREFIX_BYTES);

    logic [7:0]            b;
    logic                  plain;
    logic                  start_hit;
    logic [3:0]            start_kind;
    logic [3:0]            start_count;
    logic [C_VALUE_W-1:0]  asm_merged;
    logic [C_VALUE_W-1:0]  asm_op;
    logic                  op_last;
    logic                  op_float;
    logic                  op_accum;
    logic                  prefix_active;
    logic [C_PREFIX_W-1:0] prefix_inc;
    logic [7:0]            func_v;
    logic                  is_small;
    logic                  is_keyword;
    logic                  is_print;
    logic                  is_kana;

    assign b             = i_data_byte;
    assign plain         = !i_state.quote && !i_state.rem_data;
    assign op_last       = (i_state.bytes_left <= 4'd1);
    assign op_float      = (i_state.op_kind == K_FLOAT4[3:0]) ||
                           (i_state.op_kind == K_FLOAT8[3:0]);
    // The exponent byte of a float is not packed into the mantissa.
    assign op_accum      = !(op_float && op_last);
    assign asm_op        = op_accum ? asm_merged : i_state.assembly;
    assign func_v        = asm_op[7:0];
    assign prefix_active = i_skip_prefix && (i_state.prefix_count < LP_PREFIX);
    assign prefix_inc    = i_state.prefix_count + 1'b1;
    assign is_small      = (b >= B_SMALL_LO) && (b <= B_SMALL_HI);
    assign is_keyword    = (b >= B_KW_LO) && (b <= B_KW_HI);
    assign is_print      = (b >= B_PRINT_LO) && (b <= B_PRINT_HI);
    assign is_kana       = (b >= B_KANA_LO) && (b <= B_KANA_HI);

    // Operand lead-in codes, recognized in every text mode.
    always_comb begin
        start_hit   = 1'b1;
        start_kind  = 4'd0;
        start_count = 4'd2;
        case (b)
            B_OCTAL:      start_kind = K_OCTAL[3:0];
            B_HEX:        start_kind = K_HEX[3:0];
            B_ABS_ADDR:   start_kind = K_ABS_ADDR[3:0];
            B_LINE_REF:   start_kind = K_LINE_REF[3:0];
            B_BYTE_CONST: begin
                start_kind  = K_SMALL_CONST[3:0];
                start_count = 4'd1;
            end
            B_SIGNED_INT: start_kind = K_SIGNED_INT[3:0];
            B_FLOAT4: begin
                start_kind  = K_FLOAT4[3:0];
                start_count = 4'd4;
            end
            B_FLOAT8: begin
                start_kind  = K_FLOAT8[3:0];
                start_count = 4'd8;
            end
            default:      start_hit = 1'b0;
        endcase
    end

    // Byte lane write of the operand assembly register.
    always_comb begin
        for (int i = 0; i < C_LANES; i++) begin
            asm_merged[8*i +: 8] = (i_state.op_shift == 3'(i)) ? b : i_state.assembly[8*i +: 8];
        end
    end

    // Next parse state.
    always_comb begin
        o_state = i_state;
        if (i_state.phase != PH_HALT) begin
            if (i_end_of_input) begin
                o_state.phase = PH_HALT;
            end else begin
                case (i_state.phase)
                    PH_START: begin
                        if (prefix_active) begin
                            o_state.prefix_count = prefix_inc;
                            if (prefix_inc >= LP_PREFIX) begin
                                o_state.phase = PH_LINK_LO;
                            end
                        end else begin
                            o_state.link_lo_zero = (b == 8'd0);
                            o_state.phase        = PH_LINK_HI;
                        end
                    end
                    PH_LINK_LO: begin
                        o_state.link_lo_zero = (b == 8'd0);
                        o_state.phase        = PH_LINK_HI;
                    end
                    PH_LINK_HI: begin
                        if (i_state.link_lo_zero && (b == 8'd0)) begin
                            o_state.phase = PH_HALT;
                        end else begin
                            o_state.phase = PH_NUM_LO;
                        end
                    end
                    PH_NUM_LO: begin
                        o_state.assembly = {{(C_VALUE_W-8){1'b0}}, b};
                        o_state.phase    = PH_NUM_HI;
                    end
                    PH_NUM_HI: begin
                        o_state.assembly = {{(C_VALUE_W-16){1'b0}}, b, i_state.assembly[7:0]};
                        o_state.quote    = 1'b0;
                        o_state.rem_data = 1'b0;
                        o_state.phase    = PH_BODY;
                    end
                    PH_BODY: begin
                        if (b == B_LINE_END) begin
                            o_state.phase = PH_LINK_LO;
                        end else if (start_hit || ((b == B_FUNC_PREFIX) && plain)) begin
                            o_state.op_kind    = start_hit ? start_kind : K_FUNCTION[3:0];
                            o_state.bytes_left = start_hit ? start_count : 4'd1;
                            o_state.op_shift   = 3'd0;
                            o_state.assembly   = '0;
                            o_state.phase      = PH_OPERAND;
                        end else if (is_keyword && plain) begin
                            if ((b == B_REM) || (b == B_DATA)) begin
                                o_state.rem_data = 1'b1;
                            end
                        end else if (b == B_QUOTE) begin
                            o_state.quote = !i_state.quote;
                        end else if (!i_state.quote && (b == B_COLON)) begin
                            o_state.rem_data = 1'b0;
                        end
                    end
                    PH_OPERAND: begin
                        if (op_accum) begin
                            o_state.assembly = asm_merged;
                            o_state.op_shift = i_state.op_shift + 3'd1;
                        end
                        if (op_last) begin
                            o_state.bytes_left = 4'd0;
                            o_state.phase      = PH_BODY;
                        end else begin
                            o_state.bytes_left = i_state.bytes_left - 4'd1;
                        end
                    end
                    default: o_state.phase = PH_HALT;
                endcase
            end
        end
    end

    // Token produced by this byte, if any.
    always_comb begin
        o_token_valid = 1'b0;
        o_token       = '0;
        if (i_state.phase != PH_HALT) begin
            if (i_end_of_input) begin
                o_token_valid = 1'b1;
                o_token.kind  = K_ERROR;
            end else begin
                case (i_state.phase)
                    PH_LINK_HI: begin
                        if (i_state.link_lo_zero && (b == 8'd0)) begin
                            o_token_valid = 1'b1;
                            o_token.kind  = K_END_PROGRAM;
                        end
                    end
                    PH_NUM_HI: begin
                        o_token_valid = 1'b1;
                        o_token.kind  = K_LINE_START;
                        o_token.value = {{(C_VALUE_W-16){1'b0}}, b, i_state.assembly[7:0]};
                    end
                    PH_BODY: begin
                        o_token_valid = 1'b1;
                        o_token.value = {{(C_VALUE_W-8){1'b0}}, b};
                        if (b == B_LINE_END) begin
                            o_token.kind  = K_END_LINE;
                            o_token.value = '0;
                        end else if (start_hit || ((b == B_FUNC_PREFIX) && plain)) begin
                            o_token_valid = 1'b0;
                        end else if (is_small) begin
                            o_token.kind  = K_SMALL_CONST;
                            o_token.value = {{(C_VALUE_W-8){1'b0}}, b - B_SMALL_LO};
                        end else if (is_keyword && plain) begin
                            o_token.kind  = K_KEYWORD;
                            o_token.value = {{(C_VALUE_W-8){1'b0}}, b - B_KW_LO};
                        end else if (is_print) begin
                            if (!i_state.quote && (b == B_COLON) && i_pretty_layout) begin
                                o_token.kind = K_STMT_BREAK;
                            end else begin
                                o_token.kind = K_CHAR;
                            end
                        end else if (is_kana) begin
                            o_token.kind = K_CHAR;
                        end else begin
                            o_token.kind = K_UNKNOWN;
                        end
                    end
                    PH_OPERAND: begin
                        if (op_last) begin
                            o_token_valid = 1'b1;
                            case (i_state.op_kind)
                                K_FLOAT4[3:0]: begin
                                    o_token.kind  = K_FLOAT4;
                                    o_token.value = {{(C_VALUE_W-24){1'b0}}, asm_op[23:0]};
                                    o_token.expo  = b;
                                end
                                K_FLOAT8[3:0]: begin
                                    o_token.kind  = K_FLOAT8;
                                    o_token.value = asm_op;
                                    o_token.expo  = b;
                                end
                                K_FUNCTION[3:0]: begin
                                    if (func_v == B_IEEE) begin
                                        o_token.kind = K_IEEE;
                                    end else if ((func_v >= B_KW_LO) && (func_v <= B_FUNC_HI)) begin
                                        o_token.kind  = K_FUNCTION;
                                        o_token.value = {{(C_VALUE_W-8){1'b0}}, func_v - B_KW_LO};
                                    end else begin
                                        // Unassigned function codes are dropped.
                                        o_token_valid = 1'b0;
                                    end
                                end
                                default: begin
                                    o_token.kind  = {1'b0, i_state.op_kind};
                                    o_token.value = {{(C_VALUE_W-16){1'b0}}, asm_op[15:0]};
                                end
                            endcase
                        end
                    end
                    default: o_token_valid = 1'b0;
                endcase
            end
        end
    end

endmodule

### rtl/basic_program_token_parser.sv
// Top level: input register, parse step, parse state and token output register.
// A result passes through the input register and then the token output register after its byte is accepted.
// Throughput: one byte per cycle, limited only by the output ready.
// Bytes that finish no token (headers, operand bytes, skipped prefix) give no result.
// Reset is synchronous: it clears the parse state, both configuration bits and all valids.
// After an end-of-program or error token the parser takes bytes and gives nothing until reset.
`include "basic_program_token_parser_macros.svh"

module basic_program_token_parser #(
    parameter int unsigned PREFIX_BYTES = tkp_pkg::C_PREFIX_BYTES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic                         i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_end_of_input,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [4:0]                   o_token_kind,
    output logic [tkp_pkg::C_VALUE_W-1:0] o_token_value,
    output logic [7:0]                   o_float_exponent
);
    import tkp_pkg::*;

    logic         r_pretty_layout;
    logic         r_skip_prefix;
    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_eoi;
    t_parse_state r_state;
    t_parse_state n_state;
    logic         r_out_valid;
    t_token       r_token;
    t_token       n_token;
    logic         n_token_valid;
    logic         w_advance;

    // The held byte moves on whenever the output slot is free or being emptied.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    tkp_decode #(
        .PREFIX_BYTES(PREFIX_BYTES)
    ) u_decode (
        .i_state        (r_state),
        .i_data_byte    (r_in_byte),
        .i_end_of_input (r_in_eoi),
        .i_pretty_layout(r_pretty_layout),
        .i_skip_prefix  (r_skip_prefix),
        .o_state        (n_state),
        .o_token_valid  (n_token_valid),
        .o_token        (n_token)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pretty_layout <= 1'b0;
            r_skip_prefix   <= 1'b0;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_state         <= C_STATE_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PRETTY_LAYOUT:    r_pretty_layout <= i_cfg_data;
                    CFG_SKIP_TAPE_PREFIX: r_skip_prefix   <= i_cfg_data;
                    default:              r_pretty_layout <= r_pretty_layout;
                endcase
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_state     <= n_state;
                r_out_valid <= n_token_valid;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
            r_in_eoi  <= i_end_of_input;
        end
        if (w_advance && n_token_valid) begin
            r_token <= n_token;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_token_kind     = r_token.kind;
    assign o_token_value    = r_token.value;
    assign o_float_exponent = r_token.expo;

    `TKP_ASSERT_NEXT(a_halt_sticky, r_state.phase == PH_HALT, r_state.phase == PH_HALT,
        "parser left the halt phase without reset")
    `TKP_ASSERT_NOW(a_final_token_halts,
        r_out_valid && ((r_token.kind == K_ERROR) || (r_token.kind == K_END_PROGRAM)),
        r_state.phase == PH_HALT, "final token shown while parser not halted")
    `TKP_ASSERT_NOW(a_operand_count_idle,
        (r_state.phase != PH_OPERAND) && (r_state.phase != PH_HALT),
        r_state.bytes_left == 4'd0, "operand byte count left over outside an operand")
    `TKP_ASSERT_NOW(a_exponent_only_float,
        r_out_valid && (r_token.kind != K_FLOAT4) && (r_token.kind != K_FLOAT8),
        r_token.expo == 8'd0, "exponent set on a non-float token")

endmodule
